// ----- rtl/c2p_pkg.sv -----
// Shared types, constants and the elementary angle table of the polar converter.
package c2p_pkg;

	localparam int GUARD = 14;                     // guard bits below the input LSB
	localparam int ZW    = 28;                     // angle accumulator, radians * 2^24
	localparam int AW    = 17;                     // output angle, radians * 2^13
	localparam int MAGW  = 16;                     // output magnitude
	localparam int RSH   = 11;                     // Q24 -> Q13
	localparam int LOW_W = 16;                     // low slice of x in the gain multiply
	localparam logic [31:0] INV_GAIN_Q32 = 32'h9B74_EDA8;
	localparam logic signed [AW-1:0] HALF_PI_Q13 = 17'sd12868;
	localparam logic signed [AW-1:0] PI_Q13      = 17'sd25736;

	// Per-word flags that travel beside the datapath.
	typedef struct packed {
		logic             neg;     // real part negative, pi added at the end
		logic             axis;    // real part zero
		logic             im_pos;  // imaginary part strictly positive
		logic [MAGW-1:0]  abs_im;  // magnitude used on the imaginary axis
	} c2p_side_t;

	// atan(2^-i) in radians * 2^24, rounded to nearest.
	function automatic logic signed [ZW-1:0] elem_angle(input int unsigned i);
		logic signed [ZW-1:0] a;
		case (i)
			0: a = 28'sd13176795;
			1: a = 28'sd7778716;
			2: a = 28'sd4110060;
			3: a = 28'sd2086331;
			4: a = 28'sd1047214;
			5: a = 28'sd524117;
			6: a = 28'sd262123;
			7: a = 28'sd131069;
			8: a = 28'sd65536;
			default: begin
				if (i > 24) a = '0;
				else        a = ZW'(1) <<< (24 - i);
			end
		endcase
		return a;
	endfunction

endpackage

// ----- rtl/c2p_in_if.sv -----
// Input channel: one complex sample per word.
interface c2p_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] real_part;
	logic signed [15:0] imag_part;

	modport source(output valid, output real_part, output imag_part, input ready);
	modport sink(input valid, input real_part, input imag_part, output ready);
endinterface

// ----- rtl/c2p_out_if.sv -----
// Output channel: modulus, argument and axis flag per word.
interface c2p_out_if;
	logic               valid;
	logic               ready;
	logic        [15:0] magnitude;
	logic signed [16:0] angle;
	logic               on_axis;

	modport source(output valid, output magnitude, output angle, output on_axis, input ready);
	modport sink(input valid, input magnitude, input angle, input on_axis, output ready);
endinterface

// ----- rtl/c2p_prep.sv -----
// Input stage: width extension, rotation by pi for a negative real part, guard scaling.
module c2p_prep
	import c2p_pkg::*;
#(
	parameter int DATA_WIDTH = 16,
	parameter int IW         = 16,
	parameter int XW         = 33
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 valid,
	input  logic signed [15:0]   real_part,
	input  logic signed [15:0]   imag_part,
	output logic                 valid_s1,
	output logic signed [XW-1:0] x_s1,
	output logic signed [XW-1:0] y_s1,
	output logic signed [ZW-1:0] z_s1,
	output c2p_side_t            side_s1
);

	logic signed [IW-1:0] re_e;
	logic signed [IW-1:0] im_e;
	logic signed [XW-1:0] re_x;
	logic signed [XW-1:0] im_x;
	logic signed [XW-1:0] abs_x;
	logic                 neg;
	c2p_side_t            side;

	generate
		if (DATA_WIDTH > 16) begin : g_wide
			// read the field as non-negative
			assign re_e = {1'b0, real_part};
			assign im_e = {1'b0, imag_part};
		end else begin : g_narrow
			assign re_e = real_part[IW-1:0];
			assign im_e = imag_part[IW-1:0];
		end
	endgenerate

	always_comb begin
		re_x  = XW'(re_e);
		im_x  = XW'(im_e);
		neg   = re_e < 0;
		abs_x = (im_e < 0) ? -im_x : im_x;
		side.neg    = neg;
		side.axis   = (re_e == '0);
		side.im_pos = (im_e > 0);
		side.abs_im = abs_x[MAGW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1    <= (neg ? -re_x : re_x) <<< GUARD;
			y_s1    <= (neg ? -im_x : im_x) <<< GUARD;
			z_s1    <= '0;
			side_s1 <= side;
		end
	end

endmodule

// ----- rtl/c2p_stage.sv -----
// One vectoring micro-rotation of the CORDIC pipeline.
module c2p_stage
	import c2p_pkg::*;
#(
	parameter int XW  = 33,
	parameter int IDX = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 valid,
	input  logic signed [XW-1:0] x,
	input  logic signed [XW-1:0] y,
	input  logic signed [ZW-1:0] z,
	input  c2p_side_t            side,
	output logic                 valid_s1,
	output logic signed [XW-1:0] x_s1,
	output logic signed [XW-1:0] y_s1,
	output logic signed [ZW-1:0] z_s1,
	output c2p_side_t            side_s1
);

	localparam logic signed [ZW-1:0] ANG = elem_angle(IDX);

	logic signed [XW-1:0] xs;
	logic signed [XW-1:0] ys;
	logic                 up;

	assign xs = x >>> IDX;
	assign ys = y >>> IDX;
	assign up = !y[XW-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid;
		end
	end

	// rotate toward the real axis
	always_ff @(posedge clk) begin
		if (en) begin
			x_s1    <= up ? x + ys : x - ys;
			y_s1    <= up ? y - xs : y + xs;
			z_s1    <= up ? z + ANG : z - ANG;
			side_s1 <= side;
		end
	end

endmodule

// ----- rtl/c2p_post.sv -----
// Output stages: gain correction as two partial products, angle rounding and axis override.
module c2p_post
	import c2p_pkg::*;
#(
	parameter int XW = 33
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 valid,
	input  logic signed [XW-1:0] x,
	input  logic signed [ZW-1:0] z,
	input  c2p_side_t            side,
	output logic                 valid_s2,
	output logic [MAGW-1:0]      mag_s2,
	output logic signed [AW-1:0] ang_s2,
	output logic                 axis_s2
);

	localparam int HW = XW - 1 - LOW_W;     // high slice of the non-negative x
	localparam int PW = XW + 32;            // product plus rounding
	localparam int MS = GUARD + 32;         // drop guard bits and Q32 gain

	logic [LOW_W-1:0]       xl;
	logic [HW-1:0]          xh;
	logic signed [ZW-1:0]   zr_w;
	logic signed [AW-1:0]   zr;
	logic signed [AW-1:0]   ang_c;
	logic [PW-1:0]          sum;
	logic [PW-1:0]          shf;
	logic [MAGW-1:0]        mag_c;

	logic                   valid_s1;
	logic [LOW_W+31:0]      plo_s1;
	logic [HW+31:0]         phi_s1;
	logic signed [AW-1:0]   ang_s1;
	c2p_side_t              side_s1;

	assign xl = x[LOW_W-1:0];
	assign xh = x[XW-2:LOW_W];

	always_comb begin
		zr_w = (z + ZW'(1024)) >>> RSH;
		zr   = zr_w[AW-1:0];
		if (zr > HALF_PI_Q13)       ang_c = HALF_PI_Q13;
		else if (zr < -HALF_PI_Q13) ang_c = -HALF_PI_Q13;
		else                        ang_c = zr;
		if (side.neg) ang_c = ang_c + PI_Q13;
	end

	always_comb begin
		sum = (PW'(phi_s1) << LOW_W) + PW'(plo_s1) + (PW'(1) << (MS - 1));
		shf = sum >> MS;
		if (shf > PW'(17'h0FFFF)) mag_c = '1;
		else                      mag_c = shf[MAGW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			plo_s1  <= (LOW_W + 32)'(xl) * (LOW_W + 32)'(INV_GAIN_Q32);
			phi_s1  <= (HW + 32)'(xh) * (HW + 32)'(INV_GAIN_Q32);
			ang_s1  <= ang_c;
			side_s1 <= side;
			// the imaginary axis bypasses the rotation result
			mag_s2  <= side_s1.axis ? side_s1.abs_im : mag_c;
			ang_s2  <= side_s1.axis ? (side_s1.im_pos ? HALF_PI_Q13 : -HALF_PI_Q13) : ang_s1;
			axis_s2 <= side_s1.axis;
		end
	end

endmodule

// ----- rtl/complex_to_polar_converter.sv -----
// Path from an accepted sample to its result: the input register, one register per
// micro-rotation, then two output registers for the gain multiply.
// Throughput: one word per cycle; the whole pipeline advances together and holds
// while the output word waits, so the input is stalled only when the output is.
// Reset clears the valid bits of every stage; data registers are not reset.
module complex_to_polar_converter
	import c2p_pkg::*;
#(
	parameter int DATA_WIDTH = 16,
	parameter int STAGES     = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	c2p_in_if.sink   sample,
	c2p_out_if.source polar
);

	localparam int IW = (DATA_WIDTH > 16) ? 17 : DATA_WIDTH;
	localparam int XW = IW + 1 + GUARD + 2;

	logic                 en;
	logic                 vld [STAGES+1];
	logic signed [XW-1:0] xv  [STAGES+1];
	logic signed [XW-1:0] yv  [STAGES+1];
	logic signed [ZW-1:0] zv  [STAGES+1];
	c2p_side_t            sd  [STAGES+1];

	// advance everything unless the output word is held
	assign en           = !polar.valid || polar.ready;
	assign sample.ready = en;

	c2p_prep #(
		.DATA_WIDTH(DATA_WIDTH),
		.IW        (IW),
		.XW        (XW)
	) u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid    (sample.valid),
		.real_part(sample.real_part),
		.imag_part(sample.imag_part),
		.valid_s1 (vld[0]),
		.x_s1     (xv[0]),
		.y_s1     (yv[0]),
		.z_s1     (zv[0]),
		.side_s1  (sd[0])
	);

	generate
		for (genvar i = 0; i < STAGES; i++) begin : g_rot
			c2p_stage #(
				.XW (XW),
				.IDX(i)
			) u_stage (
				.clk     (clk),
				.arst_n  (arst_n),
				.en      (en),
				.valid   (vld[i]),
				.x       (xv[i]),
				.y       (yv[i]),
				.z       (zv[i]),
				.side    (sd[i]),
				.valid_s1(vld[i+1]),
				.x_s1    (xv[i+1]),
				.y_s1    (yv[i+1]),
				.z_s1    (zv[i+1]),
				.side_s1 (sd[i+1])
			);
		end
	endgenerate

	c2p_post #(
		.XW(XW)
	) u_post (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.valid   (vld[STAGES]),
		.x       (xv[STAGES]),
		.z       (zv[STAGES]),
		.side    (sd[STAGES]),
		.valid_s2(polar.valid),
		.mag_s2  (polar.magnitude),
		.ang_s2  (polar.angle),
		.axis_s2 (polar.on_axis)
	);

	a_axis_angle: assert property (@(posedge clk) disable iff (!arst_n)
		polar.valid && polar.on_axis |-> polar.angle == HALF_PI_Q13 ||
			polar.angle == -HALF_PI_Q13)
		else $error("axis word with angle other than +-pi/2");

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		polar.valid |-> polar.angle >= -HALF_PI_Q13 &&
			polar.angle <= HALF_PI_Q13 + PI_Q13)
		else $error("angle out of range");

	a_no_take_on_hold: assert property (@(posedge clk) disable iff (!arst_n)
		polar.valid && !polar.ready |-> !(sample.valid && sample.ready))
		else $error("sample taken while output word held");

	a_hold_word: assert property (@(posedge clk) disable iff (!arst_n)
		polar.valid && !polar.ready |=> polar.valid && $stable(polar.magnitude) &&
			$stable(polar.angle))
		else $error("held output word changed");

endmodule

// ----- test/complex_to_polar_converter_tb.sv -----
// Testbench for the CORDIC complex-to-polar converter: random traffic checked word by word.
`timescale 1ns / 100ps

module complex_to_polar_converter_tb;
	import c2p_pkg::*;

	localparam int DATA_WIDTH = 16;
	localparam int STAGES     = 16;
	localparam int LATENCY    = STAGES + 3;
	localparam int IDLE_LIMIT = 1000;
	localparam int HOLD_LEN   = 80;
	localparam int MAX_PRINTS = 40;

	typedef struct packed {
		logic        [15:0] magnitude;
		logic signed [16:0] angle;
		logic               on_axis;
	} polar_word_t;

	class polar_scoreboard;
		polar_word_t pending_polar[$];
		int rotations;
		int errors;
		int samples;
		int words;
		int axis_samples;
		int left_samples;

		function new(int n);
			rotations = n;
		endfunction

		// atan(2^-i) in radians * 2^24
		function longint atan_q24(int i);
			case (i)
				0: return 64'sd13176795;
				1: return 64'sd7778716;
				2: return 64'sd4110060;
				3: return 64'sd2086331;
				4: return 64'sd1047214;
				5: return 64'sd524117;
				6: return 64'sd262123;
				7: return 64'sd131069;
				8: return 64'sd65536;
				default: return (i > 24) ? 64'sd0 : (64'sd1 <<< (24 - i));
			endcase
		endfunction

		function polar_word_t polar_of(logic signed [15:0] re, logic signed [15:0] im);
			polar_word_t w;
			longint r, q, x, y, z, xs, ys, ang;
			logic [63:0] prod, mag;
			r = re;
			q = im;
			if (r == 0) begin
				w.magnitude = 16'((q < 0) ? -q : q);
				w.angle = (q > 0) ? HALF_PI_Q13 : -HALF_PI_Q13;
				w.on_axis = 1'b1;
				return w;
			end
			// fold the left half plane onto the right one
			x = ((r > 0) ? r : -r) * (64'sd1 <<< GUARD);
			y = ((r > 0) ? q : -q) * (64'sd1 <<< GUARD);
			z = 0;
			for (int i = 0; i < rotations; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (y >= 0) begin
					x = x + ys;
					y = y - xs;
					z = z + atan_q24(i);
				end else begin
					x = x - ys;
					y = y + xs;
					z = z - atan_q24(i);
				end
			end
			prod = 64'(x) * 64'(INV_GAIN_Q32) + (64'd1 << (31 + GUARD));
			mag = prod >> (32 + GUARD);
			if (mag > 64'hFFFF) mag = 64'hFFFF;
			ang = (z + 1024) >>> 11;
			if (ang > HALF_PI_Q13) ang = HALF_PI_Q13;
			if (ang < -HALF_PI_Q13) ang = -HALF_PI_Q13;
			if (r < 0) ang = ang + PI_Q13;
			w.magnitude = mag[15:0];
			w.angle = 17'(ang);
			w.on_axis = 1'b0;
			return w;
		endfunction

		function void note_sample(logic signed [15:0] re, logic signed [15:0] im);
			samples++;
			if (re == 0) axis_samples++;
			if (re < 0) left_samples++;
			pending_polar.push_back(polar_of(re, im));
		endfunction

		task report(string what);
			errors++;
			if (errors <= MAX_PRINTS) $display("[%0t] mismatch: %s", $time, what);
		endtask

		task check_word(polar_word_t got);
			polar_word_t want;
			words++;
			if (pending_polar.size() == 0) begin
				report($sformatf("word with no sample pending: mag=%0d ang=%0d axis=%0b",
					got.magnitude, got.angle, got.on_axis));
				return;
			end
			want = pending_polar.pop_front();
			if (got.magnitude !== want.magnitude)
				report($sformatf("word %0d magnitude %0d, want %0d",
					words, got.magnitude, want.magnitude));
			if (got.angle !== want.angle)
				report($sformatf("word %0d angle %0d, want %0d", words, got.angle, want.angle));
			if (got.on_axis !== want.on_axis)
				report($sformatf("word %0d on_axis %0b, want %0b",
					words, got.on_axis, want.on_axis));
		endtask

		task check_drained();
			if (pending_polar.size() != 0)
				report($sformatf("%0d results never arrived", pending_polar.size()));
		endtask
	endclass

	logic clk;
	logic arst_n;
	bit   burst;
	int   out_hold;

	c2p_in_if  sample_ch();
	c2p_out_if polar_ch();

	polar_scoreboard sb;

	complex_to_polar_converter #(
		.DATA_WIDTH(DATA_WIDTH),
		.STAGES(STAGES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample(sample_ch),
		.polar(polar_ch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Offer one sample after a random gap and hold it until taken.
	task send_sample(logic signed [15:0] re, logic signed [15:0] im);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.real_part <= re;
		sample_ch.imag_part <= im;
		do @(posedge clk); while (!sample_ch.ready);
		sb.note_sample(re, im);
	endtask

	task send_random();
		logic signed [15:0] re, im;
		logic signed [15:0] corner[7];
		corner = '{-16'sd32768, -16'sd32767, -16'sd1, 16'sd0, 16'sd1, 16'sd32766, 16'sd32767};
		re = 16'($urandom);
		im = 16'($urandom);
		case ($urandom_range(0, 9))
			4, 5: begin
				re = 16'(int'($urandom_range(0, 16)) - 8);
				im = 16'(int'($urandom_range(0, 16)) - 8);
			end
			6: re = '0;
			7: case ($urandom_range(0, 2))
				0: im = '0;
				1: im = re;
				default: im = -re;
			endcase
			8: begin
				re = corner[$urandom_range(0, 6)];
				im = corner[$urandom_range(0, 6)];
			end
			9: re = {re[15], ~re[15], re[13:0]};
			default: ;
		endcase
		send_sample(re, im);
	endtask

	task wait_drained();
		while (sb.pending_polar.size() != 0) @(posedge clk);
	endtask

	// Result side: random stalls, plus a long hold-off on request.
	initial begin
		int stall;
		polar_word_t got;
		polar_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = burst ? 0 : $urandom_range(0, 3);
			if (out_hold > 0) begin
				stall = out_hold;
				out_hold = 0;
			end
			if (stall > 0) begin
				polar_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			polar_ch.ready <= 1'b1;
			do @(posedge clk); while (!polar_ch.valid);
			got.magnitude = polar_ch.magnitude;
			got.angle = polar_ch.angle;
			got.on_axis = polar_ch.on_axis;
			sb.check_word(got);
		end
	end

	initial begin
		int idle;
		idle = 0;
		forever begin
			@(posedge clk);
			if ((sample_ch.valid && sample_ch.ready) || (polar_ch.valid && polar_ch.ready))
				idle = 0;
			else
				idle++;
			if (idle >= IDLE_LIMIT) begin
				$display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	initial begin
		logic signed [15:0] dir_re[$];
		logic signed [15:0] dir_im[$];
		sb = new(STAGES);
		burst = 1'b0;
		out_hold = 0;
		arst_n <= 1'b0;
		sample_ch.valid <= 1'b0;
		sample_ch.real_part <= '0;
		sample_ch.imag_part <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// axes, origin, corners, clamp region near the imaginary axis, left half plane
		dir_re = '{16'sd32767, -16'sd32768, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
			-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767, 16'sd1, -16'sd1, 16'sd1,
			-16'sd1, 16'sd1, -16'sd1, 16'sd1, 16'sd1, -16'sd1, -16'sd1, -16'sd32768,
			-16'sd32768, 16'sd100, -16'sd5};
		dir_im = '{16'sd0, 16'sd0, 16'sd32767, -16'sd32768, 16'sd0, 16'sd1, -16'sd1,
			-16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768, 16'sd0, 16'sd0, 16'sd1,
			-16'sd1, -16'sd1, 16'sd1, 16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768,
			16'sd1, -16'sd1, -16'sd32768, 16'sd0};
		foreach (dir_re[i]) send_sample(dir_re[i], dir_im[i]);

		repeat (600) send_random();

		burst = 1'b1;
		repeat (300) send_random();
		burst = 1'b0;

		// pause the sender until the pipeline is empty
		sample_ch.valid <= 1'b0;
		wait_drained();
		@(posedge clk);

		// stall the result side long enough for the input to back up
		out_hold = HOLD_LEN;
		burst = 1'b1;
		repeat (100) send_random();
		burst = 1'b0;

		repeat (620) send_random();
		sample_ch.valid <= 1'b0;

		wait_drained();
		repeat (LATENCY + 4) @(posedge clk);
		sb.check_drained();

		$display("%0d samples sent, %0d results checked", sb.samples, sb.words);
		$display("%0d on the imaginary axis, %0d with negative real part",
			sb.axis_samples, sb.left_samples);
		if (sb.errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("%0d mismatches", sb.errors);
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
